@@ rtl/core/bcdc_pkg.sv @@
// ----------------------------------------------------------------------------
// Battery charge/discharge controller package
// Widths, register indexes, reset values, mode encodings and shared types.
// ----------------------------------------------------------------------------
package bcdc_pkg;

    localparam int TS_W              = 32;
    localparam int MV_W              = 16;
    localparam int MA_W              = 16;
    localparam int MODE_W            = 3;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 32;
    localparam int DEFAULT_TICK_BITS = 32;

    localparam logic [MV_W-1:0] RST_OVER_VOLTAGE_MV  = 16'd21000;
    localparam logic [MV_W-1:0] RST_UNDER_VOLTAGE_MV = 16'd16000;
    localparam logic [MA_W-1:0] RST_CURRENT_FLOOR_MA = 16'd300;
    localparam logic [TS_W-1:0] RST_SETTLE_MS        = 32'd50000;
    localparam logic [TS_W-1:0] RST_VOLT_CONFIRM_MS  = 32'd50000;
    localparam logic [TS_W-1:0] RST_DONE_CONFIRM_MS  = 32'd30000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OVER_VOLTAGE  = 3'd0,
        CFG_UNDER_VOLTAGE = 3'd1,
        CFG_CURRENT_FLOOR = 3'd2,
        CFG_SETTLE        = 3'd3,
        CFG_VOLT_CONFIRM  = 3'd4,
        CFG_DONE_CONFIRM  = 3'd5
    } t_cfg_idx;

    typedef enum logic [4:0] {
        MODE_IDLE     = 5'b00001,
        MODE_CHG      = 5'b00010,
        MODE_DIS      = 5'b00100,
        MODE_CHG_DONE = 5'b01000,
        MODE_DIS_DONE = 5'b10000
    } t_mode;

    localparam logic [MODE_W-1:0] CODE_IDLE     = 3'd0;
    localparam logic [MODE_W-1:0] CODE_CHG      = 3'd1;
    localparam logic [MODE_W-1:0] CODE_DIS      = 3'd2;
    localparam logic [MODE_W-1:0] CODE_CHG_DONE = 3'd3;
    localparam logic [MODE_W-1:0] CODE_DIS_DONE = 3'd4;

    // Control of one confirmation wait for one step.
    typedef struct packed {
        logic eval;
        logic clear;
        logic cond;
    } t_wait_ctl;

    function automatic logic [MODE_W-1:0] mode_code(t_mode m);
        logic [MODE_W-1:0] c;
        unique case (m)
            MODE_IDLE:     c = CODE_IDLE;
            MODE_CHG:      c = CODE_CHG;
            MODE_DIS:      c = CODE_DIS;
            MODE_CHG_DONE: c = CODE_CHG_DONE;
            MODE_DIS_DONE: c = CODE_DIS_DONE;
            default:       c = CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/bcdc_if.sv @@
// ----------------------------------------------------------------------------
// Battery charge/discharge controller channels
// Evaluation input, result output and register write channels.
// ----------------------------------------------------------------------------
interface bcdc_in_if;
    logic                       valid;
    logic                       ready;
    logic [bcdc_pkg::TS_W-1:0]  now_ms;
    logic [bcdc_pkg::MV_W-1:0]  battery_mv;
    logic [bcdc_pkg::MA_W-1:0]  charge_ma;
    logic [bcdc_pkg::MA_W-1:0]  discharge_ma;
    logic                       start_charge;
    logic                       stop_charge;
    logic                       start_discharge;
    logic                       stop_discharge;

    modport source (
        output valid, now_ms, battery_mv, charge_ma, discharge_ma,
               start_charge, stop_charge, start_discharge, stop_discharge,
        input  ready
    );
    modport sink (
        input  valid, now_ms, battery_mv, charge_ma, discharge_ma,
               start_charge, stop_charge, start_discharge, stop_discharge,
        output ready
    );
endinterface

interface bcdc_out_if;
    logic                         valid;
    logic                         ready;
    logic [bcdc_pkg::MODE_W-1:0]  mode_state;
    logic                         charge_enable;
    logic                         discharge_enable;
    logic                         fan_enable;
    logic                         charge_led;
    logic                         discharge_led;

    modport source (
        output valid, mode_state, charge_enable, discharge_enable, fan_enable,
               charge_led, discharge_led,
        input  ready
    );
    modport sink (
        input  valid, mode_state, charge_enable, discharge_enable, fan_enable,
               charge_led, discharge_led,
        output ready
    );
endinterface

interface bcdc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bcdc_pkg::CFG_IDX_W-1:0]   index;
    logic [bcdc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/battery_charge_discharge_controller.sv @@
// ----------------------------------------------------------------------------
// Battery charge/discharge controller
// Session state machine with settle blanking, voltage fault and completion
// confirmation, driving charger, load, fan and LEDs.
// ----------------------------------------------------------------------------
// The block takes one evaluation beat per clock while results are taken, and
// returns one result beat for each: the beat lands in an input register,
// and one pass of compares and wrapping subtractions updates the session
// state and loads the result register once it is free or being taken. A waiting result
// does not stop the next beat from entering the input register; a beat after
// that waits until the result is taken. Timestamps are kept TICK_BITS wide
// and all elapsed times wrap at that width.
// Registers are written through the configuration channel, which is always
// ready; write them only while no evaluation is in flight.
// ----------------------------------------------------------------------------
module battery_charge_discharge_controller #(
    parameter int TICK_BITS = bcdc_pkg::DEFAULT_TICK_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bcdc_in_if.sink    i_in,
    bcdc_out_if.source o_out,
    bcdc_cfg_if.sink   i_cfg
);

    localparam int CMP_W = (TICK_BITS > bcdc_pkg::TS_W) ? TICK_BITS : bcdc_pkg::TS_W;

    // Configuration registers.
    logic [bcdc_pkg::MV_W-1:0] r_over_mv;
    logic [bcdc_pkg::MV_W-1:0] r_under_mv;
    logic [bcdc_pkg::MA_W-1:0] r_floor_ma;
    logic [bcdc_pkg::TS_W-1:0] r_settle_ms;
    logic [bcdc_pkg::TS_W-1:0] r_volt_ms;
    logic [bcdc_pkg::TS_W-1:0] r_done_ms;

    // Input register.
    logic                      r_in_valid;
    logic [bcdc_pkg::TS_W-1:0] r_now;
    logic [bcdc_pkg::MV_W-1:0] r_mv;
    logic [bcdc_pkg::MA_W-1:0] r_chg_ma;
    logic [bcdc_pkg::MA_W-1:0] r_dis_ma;
    logic                      r_start_c;
    logic                      r_stop_c;
    logic                      r_start_d;
    logic                      r_stop_d;

    // Session state.
    bcdc_pkg::t_mode           r_mode;
    logic                      r_chg_en;
    logic                      r_dis_en;
    logic [TICK_BITS-1:0]      r_cbegin;
    logic [TICK_BITS-1:0]      r_dbegin;

    // Result register.
    logic                        r_out_valid;
    logic [bcdc_pkg::MODE_W-1:0] r_out_mode;
    logic                        r_out_chg;
    logic                        r_out_dis;
    logic                        r_out_cled;
    logic                        r_out_dled;

    logic                 w_advance;
    logic [TICK_BITS-1:0] w_now;
    bcdc_pkg::t_mode      w_mid_mode;
    logic                 w_mid_chg;
    logic                 w_mid_dis;
    logic [TICK_BITS-1:0] n_cbegin;
    logic [TICK_BITS-1:0] n_dbegin;
    logic                 w_c_settled;
    logic                 w_d_settled;
    logic                 w_cled;
    logic                 w_dled;
    bcdc_pkg::t_wait_ctl  w_ctl_over;
    bcdc_pkg::t_wait_ctl  w_ctl_under;
    bcdc_pkg::t_wait_ctl  w_ctl_cdone;
    bcdc_pkg::t_wait_ctl  w_ctl_ddone;
    logic                 w_fire_over;
    logic                 w_fire_under;
    logic                 w_fire_cdone;
    logic                 w_fire_ddone;
    bcdc_pkg::t_mode      n_mode;
    logic                 n_chg_en;
    logic                 n_dis_en;

    assign w_advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_advance;
    assign i_cfg.ready = 1'b1;

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_over_mv   <= bcdc_pkg::RST_OVER_VOLTAGE_MV;
            r_under_mv  <= bcdc_pkg::RST_UNDER_VOLTAGE_MV;
            r_floor_ma  <= bcdc_pkg::RST_CURRENT_FLOOR_MA;
            r_settle_ms <= bcdc_pkg::RST_SETTLE_MS;
            r_volt_ms   <= bcdc_pkg::RST_VOLT_CONFIRM_MS;
            r_done_ms   <= bcdc_pkg::RST_DONE_CONFIRM_MS;
        end else if (i_cfg.valid) begin
            unique case (bcdc_pkg::t_cfg_idx'(i_cfg.index))
                bcdc_pkg::CFG_OVER_VOLTAGE:  r_over_mv   <= bcdc_pkg::MV_W'(i_cfg.data);
                bcdc_pkg::CFG_UNDER_VOLTAGE: r_under_mv  <= bcdc_pkg::MV_W'(i_cfg.data);
                bcdc_pkg::CFG_CURRENT_FLOOR: r_floor_ma  <= bcdc_pkg::MA_W'(i_cfg.data);
                bcdc_pkg::CFG_SETTLE:        r_settle_ms <= bcdc_pkg::TS_W'(i_cfg.data);
                bcdc_pkg::CFG_VOLT_CONFIRM:  r_volt_ms   <= bcdc_pkg::TS_W'(i_cfg.data);
                bcdc_pkg::CFG_DONE_CONFIRM:  r_done_ms   <= bcdc_pkg::TS_W'(i_cfg.data);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_now     <= i_in.now_ms;
            r_mv      <= i_in.battery_mv;
            r_chg_ma  <= i_in.charge_ma;
            r_dis_ma  <= i_in.discharge_ma;
            r_start_c <= i_in.start_charge;
            r_stop_c  <= i_in.stop_charge;
            r_start_d <= i_in.start_discharge;
            r_stop_d  <= i_in.stop_discharge;
        end
    end

    // ------------------------------------------------------------------------
    // Requests: stop discharge, stop charge, start charge, start discharge.
    // ------------------------------------------------------------------------
    assign w_now = TICK_BITS'(r_now);

    always_comb begin
        w_mid_mode = r_mode;
        w_mid_chg  = r_chg_en;
        w_mid_dis  = r_dis_en;
        n_cbegin   = r_cbegin;
        n_dbegin   = r_dbegin;
        if (r_stop_d && (w_mid_mode == bcdc_pkg::MODE_DIS ||
                         w_mid_mode == bcdc_pkg::MODE_DIS_DONE)) begin
            w_mid_dis  = 1'b0;
            w_mid_mode = bcdc_pkg::MODE_IDLE;
        end
        if (r_stop_c && (w_mid_mode == bcdc_pkg::MODE_CHG ||
                         w_mid_mode == bcdc_pkg::MODE_CHG_DONE)) begin
            w_mid_chg  = 1'b0;
            w_mid_mode = bcdc_pkg::MODE_IDLE;
        end
        if (r_start_c && w_mid_mode == bcdc_pkg::MODE_IDLE) begin
            w_mid_chg  = 1'b1;
            w_mid_mode = bcdc_pkg::MODE_CHG;
            n_cbegin   = w_now;
        end
        if (r_start_d && w_mid_mode == bcdc_pkg::MODE_IDLE) begin
            w_mid_dis  = 1'b1;
            w_mid_mode = bcdc_pkg::MODE_DIS;
            n_dbegin   = w_now;
        end
    end

    assign w_cled      = (w_mid_mode == bcdc_pkg::MODE_CHG);
    assign w_dled      = (w_mid_mode == bcdc_pkg::MODE_DIS);
    assign w_c_settled = CMP_W'(TICK_BITS'(w_now - n_cbegin)) >= CMP_W'(r_settle_ms);
    assign w_d_settled = CMP_W'(TICK_BITS'(w_now - n_dbegin)) >= CMP_W'(r_settle_ms);

    // ------------------------------------------------------------------------
    // Confirmation waits. Idle disarms only the two voltage-fault waits.
    // ------------------------------------------------------------------------
    always_comb begin
        w_ctl_over.clear  = (w_mid_mode == bcdc_pkg::MODE_IDLE);
        w_ctl_over.eval   = w_cled && w_c_settled;
        w_ctl_over.cond   = (r_mv >= r_over_mv) && (r_chg_ma > r_floor_ma);
        w_ctl_under.clear = (w_mid_mode == bcdc_pkg::MODE_IDLE);
        w_ctl_under.eval  = w_dled && w_d_settled;
        w_ctl_under.cond  = (r_mv <= r_under_mv) && (r_dis_ma > r_floor_ma);
        w_ctl_cdone.clear = 1'b0;
        w_ctl_cdone.eval  = w_cled && w_c_settled;
        w_ctl_cdone.cond  = (r_chg_ma <= r_floor_ma);
        w_ctl_ddone.clear = 1'b0;
        w_ctl_ddone.eval  = w_dled && w_d_settled;
        w_ctl_ddone.cond  = (r_dis_ma <= r_floor_ma);
    end

    bcdc_wait #(.TICK_BITS(TICK_BITS)) u_wait_over (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_ctl   (w_ctl_over),
        .i_now   (w_now),
        .i_need  (r_volt_ms),
        .o_fire  (w_fire_over)
    );

    bcdc_wait #(.TICK_BITS(TICK_BITS)) u_wait_under (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_ctl   (w_ctl_under),
        .i_now   (w_now),
        .i_need  (r_volt_ms),
        .o_fire  (w_fire_under)
    );

    bcdc_wait #(.TICK_BITS(TICK_BITS)) u_wait_cdone (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_ctl   (w_ctl_cdone),
        .i_now   (w_now),
        .i_need  (r_done_ms),
        .o_fire  (w_fire_cdone)
    );

    bcdc_wait #(.TICK_BITS(TICK_BITS)) u_wait_ddone (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_ctl   (w_ctl_ddone),
        .i_now   (w_now),
        .i_need  (r_done_ms),
        .o_fire  (w_fire_ddone)
    );

    // Completion is applied after the fault, so it wins when both fire.
    always_comb begin
        n_mode   = w_mid_mode;
        n_chg_en = w_mid_chg;
        n_dis_en = w_mid_dis;
        if (w_fire_over) begin
            n_chg_en = 1'b0;
            n_mode   = bcdc_pkg::MODE_IDLE;
        end
        if (w_fire_cdone) begin
            n_chg_en = 1'b0;
            n_mode   = bcdc_pkg::MODE_CHG_DONE;
        end
        if (w_fire_under) begin
            n_dis_en = 1'b0;
            n_mode   = bcdc_pkg::MODE_IDLE;
        end
        if (w_fire_ddone) begin
            n_dis_en = 1'b0;
            n_mode   = bcdc_pkg::MODE_DIS_DONE;
        end
    end

    // ------------------------------------------------------------------------
    // State and result registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= bcdc_pkg::MODE_IDLE;
            r_chg_en <= 1'b0;
            r_dis_en <= 1'b0;
        end else if (w_advance) begin
            r_mode   <= n_mode;
            r_chg_en <= n_chg_en;
            r_dis_en <= n_dis_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_cbegin <= n_cbegin;
            r_dbegin <= n_dbegin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_mode <= bcdc_pkg::mode_code(n_mode);
            r_out_chg  <= n_chg_en;
            r_out_dis  <= n_dis_en;
            r_out_cled <= w_cled;
            r_out_dled <= w_dled;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.mode_state       = r_out_mode;
    assign o_out.charge_enable    = r_out_chg;
    assign o_out.discharge_enable = r_out_dis;
    // The fan is switched together with the discharge load.
    assign o_out.fan_enable       = r_out_dis;
    assign o_out.charge_led       = r_out_cled;
    assign o_out.discharge_led    = r_out_dled;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_no_dual_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_chg_en && r_dis_en))
        else $error("charger and discharge load enabled together");

    a_charging_drives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_mode == bcdc_pkg::CODE_CHG |-> r_out_chg && r_out_cled)
        else $error("charging result without charger drive or LED");

    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_now) && $stable(r_mv))
        else $error("input register overwritten while held");

endmodule

@@ rtl/core/bcdc_wait.sv @@
// ----------------------------------------------------------------------------
// Confirmation wait
// Arms on the first step its condition holds and fires once the condition
// has persisted for the required time, measured as wrapping elapsed time.
// ----------------------------------------------------------------------------
module bcdc_wait #(
    parameter int TICK_BITS = bcdc_pkg::DEFAULT_TICK_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  bcdc_pkg::t_wait_ctl        i_ctl,
    input  logic [TICK_BITS-1:0]       i_now,
    input  logic [bcdc_pkg::TS_W-1:0]  i_need,
    output logic                       o_fire
);

    localparam int CMP_W = (TICK_BITS > bcdc_pkg::TS_W) ? TICK_BITS : bcdc_pkg::TS_W;

    logic                 r_flag;
    logic                 n_flag;
    logic [TICK_BITS-1:0] r_begin;
    logic [TICK_BITS-1:0] w_elapsed;
    logic                 w_due;
    logic                 w_load;

    assign w_elapsed = i_now - r_begin;
    assign w_due     = CMP_W'(w_elapsed) >= CMP_W'(i_need);

    always_comb begin
        n_flag = r_flag;
        w_load = 1'b0;
        o_fire = 1'b0;
        if (i_ctl.clear) begin
            n_flag = 1'b0;
        end else if (i_ctl.eval) begin
            if (!i_ctl.cond) begin
                n_flag = 1'b0;
            end else if (!r_flag) begin
                n_flag = 1'b1;
                w_load = 1'b1;
            end else if (w_due) begin
                n_flag = 1'b0;
                o_fire = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else if (i_step) begin
            r_flag <= n_flag;
        end
    end

    // The begin time is only read while the wait is armed.
    always_ff @(posedge i_clk) begin
        if (i_step && w_load) begin
            r_begin <= i_now;
        end
    end

endmodule
